// ===== src/sha_pkg.sv =====
package sha_pkg;

    localparam int WordW   = 32;
    localparam int ChainN  = 8;
    localparam int BlockB  = 64;
    localparam int Rounds  = 64;
    localparam logic [7:0] PadMark = 8'h80;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_BYTE_END = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_PAD2,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       init;      // load initial chain, clear counts
        logic       absorb;    // write byte into buffer
        logic       comp_start;
        logic       pad_first; // build first padding block
        logic       pad_len;   // build zero block with length only
        logic       emit_adv;
    } t_cmd;

    typedef struct packed {
        logic       comp_busy;
        logic       block_full;
        logic       pad_two;   // padding needs an extra block
        logic       emit_last;
    } t_stat;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[i];
    endfunction

    function automatic logic [31:0] init_word(input logic mode, input logic [2:0] i);
        logic [31:0] h256 [8];
        logic [31:0] h224 [8];
        h256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        h224 = '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
                 32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};
        init_word = mode ? h224[i] : h256[i];
    endfunction

endpackage

// ===== src/sha_ctrl.sv =====
module sha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_valid,
    input  logic [1:0]     i_kind,
    output logic           o_ready,
    input  logic           i_out_ready,
    output logic           o_valid,
    input  sha_pkg::t_stat i_stat,
    output sha_pkg::t_cmd  o_cmd
);
    import sha_pkg::*;

    t_state r_state, n_state;
    logic   r_fin, n_fin;   // padding under way, digest follows its last compression
    logic   r_two, n_two;   // second padding block still to run
    logic   r_pend, n_pend; // end byte filled the block, padding still to build
    logic   acc;

    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_two   <= n_two;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_two   = r_two;
        n_pend  = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    unique case (i_kind)
                        KIND_BYTE: if (i_stat.block_full) n_state = ST_COMP;
                        KIND_BYTE_END: begin
                            if (i_stat.block_full) begin
                                n_pend = 1'b1;
                                n_state = ST_COMP;
                            end else begin
                                n_state = ST_PAD;
                            end
                        end
                        KIND_END: n_state = ST_PAD;
                        default: ;
                    endcase
                end
            end
            ST_COMP: begin
                if (!i_stat.comp_busy) begin
                    if (r_two) begin
                        n_two = 1'b0;
                        n_state = ST_PAD2;
                    end else if (r_pend) begin
                        n_pend = 1'b0;
                        n_state = ST_PAD;
                    end else if (r_fin) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                n_fin = 1'b1;
                n_two = i_stat.pad_two;
                n_state = ST_COMP;
            end
            ST_PAD2: n_state = ST_COMP;
            ST_EMIT: begin
                if (i_out_ready && i_stat.emit_last) begin
                    n_fin = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = ST_IDLE;
            n_fin = 1'b0;
            n_two = 1'b0;
            n_pend = 1'b0;
        end
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.absorb = acc && (i_kind == KIND_BYTE || i_kind == KIND_BYTE_END);
                o_cmd.comp_start = acc && i_stat.block_full
                    && (i_kind == KIND_BYTE || i_kind == KIND_BYTE_END);
            end
            ST_PAD: begin
                o_cmd.pad_first = 1'b1;
                o_cmd.comp_start = 1'b1;
            end
            ST_PAD2: begin
                o_cmd.pad_len = 1'b1;
                o_cmd.comp_start = 1'b1;
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                o_cmd.emit_adv = i_out_ready;
                o_cmd.init = i_out_ready && i_stat.emit_last;
            end
            default: ;
        endcase
        o_cmd.init = o_cmd.init | i_cfg_we;
    end

endmodule

// ===== src/sha_dp.sv =====
module sha_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic [7:0]    i_data_byte,
    input  sha_pkg::t_cmd i_cmd,
    output sha_pkg::t_stat o_stat,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);
    import sha_pkg::*;

    logic          r_mode;
    logic [31:0]   r_h [ChainN];
    logic [31:0]   r_buf [BlockB / 4];
    logic [5:0]    r_cnt;
    logic [63:0]   r_bits;
    logic [31:0]   r_w [16];
    logic [31:0]   r_v [ChainN];
    logic [6:0]    r_rnd;
    logic          r_busy;
    logic          r_fold;
    logic [2:0]    r_widx;
    logic [5:0]    pad_n;
    logic [31:0]   s0, s1, wn, t1, t2, e, a;
    logic [2:0]    last_idx;

    assign pad_n    = r_cnt;
    assign last_idx = r_mode ? 3'd6 : 3'd7;

    assign o_stat.comp_busy  = r_busy || r_fold;
    assign o_stat.block_full = (r_cnt == 6'd63);
    assign o_stat.pad_two    = (pad_n >= 6'd56);
    assign o_stat.emit_last  = (r_widx == last_idx);

    assign o_digest_word = r_h[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == last_idx);

    // message schedule and round on the sliding window
    assign s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign wn = s1 + r_w[9] + s0 + r_w[0];
    assign e  = r_v[4];
    assign a  = r_v[0];
    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_rnd[5:0]) + r_w[0];
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    // buffer held as big-endian words, byte 0 in the top lane of word 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_buf[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= i_data_byte;
        end
        if (i_cmd.pad_first) begin
            for (int i = 0; i < BlockB; i++) begin
                if (6'(i) == pad_n) begin
                    r_buf[4'(i >> 2)][8 * (3 - (i & 3)) +: 8] <= PadMark;
                end else if (6'(i) > pad_n) begin
                    r_buf[4'(i >> 2)][8 * (3 - (i & 3)) +: 8] <= (i >= 56 && pad_n < 6'd56)
                        ? 8'(r_bits >> (8 * (63 - i))) : 8'h00;
                end
            end
        end
        if (i_cmd.pad_len) begin
            for (int i = 0; i < BlockB; i++) begin
                r_buf[4'(i >> 2)][8 * (3 - (i & 3)) +: 8] <= (i >= 56)
                    ? 8'(r_bits >> (8 * (63 - i))) : 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cnt  <= '0;
            r_bits <= '0;
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_widx <= '0;
            r_rnd  <= '0;
            for (int i = 0; i < ChainN; i++) r_h[i] <= init_word(1'b0, 3'(i));
        end else begin
            if (i_cmd.absorb) begin
                r_cnt  <= r_cnt + 6'd1;
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.pad_first) begin
                r_cnt <= '0;
            end
            // buffer written this cycle, so load window next cycle
            if (i_cmd.comp_start) begin
                r_busy <= 1'b1;
                r_rnd  <= 7'd127;
            end else if (r_busy) begin
                if (r_rnd == 7'd127) begin
                    for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
                    for (int i = 0; i < ChainN; i++) r_v[i] <= r_h[i];
                    r_rnd <= '0;
                end else begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wn;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    if (r_rnd == 7'(Rounds - 1)) begin
                        r_busy <= 1'b0;
                        r_fold <= 1'b1;
                    end
                    r_rnd <= r_rnd + 7'd1;
                end
            end
            if (r_fold) begin
                r_fold <= 1'b0;
                for (int i = 0; i < ChainN; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.emit_adv) begin
                r_widx <= r_widx + 3'd1;
            end
            if (i_cmd.init) begin
                r_cnt  <= '0;
                r_bits <= '0;
                r_widx <= '0;
                for (int i = 0; i < ChainN; i++) begin
                    r_h[i] <= init_word(i_cfg_we ? i_cfg_data : r_mode, 3'(i));
                end
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

endmodule

// ===== src/sha256_224_stream_hasher_top.sv =====
// a byte that fills a block holds the input off until the compression of that block is done;
// message end adds one compression per padding block (one or two) before the first digest word
// a 64-byte block is 63 plain beats and one beat that also starts its compression
// the digest leaves one word per beat, eight for sha-256 or seven for sha-224
// reset (synchronous, active low): sha-256 mode, sha-256 initial chain, counts cleared
module sha256_224_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_cmd   cmd;
    t_stat  stat;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .o_valid     (o_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

// ===== test/sha256_224_stream_hasher_top_tb.sv =====
module sha256_224_stream_hasher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        has_word0;
        logic [31:0] word0;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_224_stream_hasher_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic        hash_mode;
    logic [31:0] hash_chain [8];
    logic [7:0]  hash_buf [64];
    int unsigned hash_fill;
    logic [63:0] hash_bits;

    t_digest_beat digest_q [$];
    int          fail_count = 0;
    int          rx_words = 0;
    int          first_word_row = -1;
    logic [31:0] first_word_want;
    bit          hold_off = 0;
    bit          hold_start = 0;
    bit          tx_live = 0;
    bit          stim_done = 0;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV_256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] IV_224 [8] = '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17,
        32'hF70E5939, 32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_chain[i] = hash_mode ? IV_224[i] : IV_256[i];
        hash_fill = 0;
        hash_bits = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {hash_buf[4*i], hash_buf[4*i+1], hash_buf[4*i+2], hash_buf[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        hash_buf[hash_fill] = b;
        hash_bits += 64'd8;
        hash_fill++;
        if (hash_fill == 64) begin
            compress_block();
            hash_fill = 0;
        end
    endfunction

    function automatic void pad_and_queue_digest();
        int nwords;
        hash_buf[hash_fill] = PadMark;
        if (hash_fill < 56) begin
            for (int i = hash_fill + 1; i < 56; i++) hash_buf[i] = '0;
        end else begin
            for (int i = hash_fill + 1; i < 64; i++) hash_buf[i] = '0;
            compress_block();
            for (int i = 0; i < 56; i++) hash_buf[i] = '0;
        end
        for (int i = 0; i < 8; i++) hash_buf[56+i] = hash_bits[63-8*i -: 8];
        compress_block();
        nwords = hash_mode ? 7 : 8;
        for (int i = 0; i < nwords; i++)
            digest_q.push_back(t_digest_beat'{hash_chain[i], 3'(i), i == nwords - 1});
        restart_message();
    endfunction

    function automatic void predict_beat(logic [1:0] kind, logic [7:0] b);
        case (kind)
            KIND_BYTE: absorb_byte(b);
            KIND_BYTE_END: begin
                absorb_byte(b);
                pad_and_queue_digest();
            end
            KIND_END: pad_and_queue_digest();
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // sender
    task automatic idle_input();
        if (tx_live) begin
            i_valid <= 1'b0;
            tx_live = 0;
        end
    endtask

    task automatic send_beat(logic [1:0] kind, logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) idle_input();
        repeat (gap) @(posedge i_clk);
        i_valid <= 1'b1;
        tx_live = 1;
        i_kind <= kind;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_beat(kind, b);
    endtask

    task automatic set_mode(logic m);
        idle_input();
        wait (digest_q.size() == 0);
        repeat (300) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hash_mode = m;
        restart_message();
    endtask

    task automatic send_message(int len, bit end_with_byte);
        for (int i = 0; i < len - 1; i++) send_beat(KIND_BYTE, 8'($urandom));
        if (end_with_byte && len > 0) send_beat(KIND_BYTE_END, 8'($urandom));
        else begin
            if (len > 0) send_beat(KIND_BYTE, 8'($urandom));
            send_beat(KIND_END, 8'($urandom));
        end
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected word", o_digest_word, '0);
            end else begin
                t_digest_beat want;
                want = digest_q.pop_front();
                if (o_digest_word !== want.word)
                    report_mismatch("digest_word", o_digest_word, want.word);
                if (o_word_index !== want.index)
                    report_mismatch("word_index", 32'(o_word_index), 32'(want.index));
                if (o_last_word !== want.last)
                    report_mismatch("last_word", 32'(o_last_word), 32'(want.last));
                if (rx_words == first_word_row && o_digest_word !== first_word_want)
                    report_mismatch("known digest", o_digest_word, first_word_want);
            end
            rx_words++;
        end
    end

    always @(posedge i_clk) begin
        int stall;
        if (hold_off) begin
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3);
            i_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // long receiver hold-off, counted here while the sender keeps going
    initial begin
        wait (hold_start);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    t_stim_row stim_rows [] = '{
        '{KIND_END,      8'h00, 1'b1, 32'he3b0c442},
        '{KIND_BYTE,     8'h61, 1'b0, '0},
        '{KIND_BYTE,     8'h62, 1'b0, '0},
        '{KIND_BYTE_END, 8'h63, 1'b1, 32'hba7816bf},
        '{KIND_UNUSED,   8'hff, 1'b0, '0},
        '{KIND_BYTE_END, 8'hff, 1'b0, '0},
        '{KIND_BYTE,     8'h00, 1'b0, '0},
        '{KIND_UNUSED,   8'h5a, 1'b0, '0},
        '{KIND_END,      8'hff, 1'b0, '0}
    };

    initial begin
        int n;
        hash_mode = 1'b0;
        for (int i = 0; i < 64; i++) hash_buf[i] = '0;
        restart_message();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].has_word0) begin
                idle_input();
                wait (digest_q.size() == 0);
                first_word_row = rx_words;
                first_word_want = stim_rows[r].word0;
            end
            send_beat(stim_rows[r].kind, stim_rows[r].data);
        end
        // padding boundaries: 55, 56, 64 bytes
        send_message(55, 1);
        send_message(56, 1);
        set_mode(1'b1);
        wait (digest_q.size() == 0);
        first_word_row = rx_words;
        first_word_want = 32'hd14a028c;
        send_beat(KIND_END, 8'h00);
        send_message(64, 0);

        // hold the receiver off while bytes keep coming
        hold_start = 1;
        send_message(3, 1);
        send_message(8, 1);

        set_mode(1'b0);
        n = 0;
        while (n < 20) begin
            int len;
            if ($urandom_range(0, 9) == 0) begin
                send_beat(KIND_UNUSED, 8'($urandom));
                continue;
            end
            if ($urandom_range(0, 19) == 0) set_mode(1'($urandom));
            len = $urandom_range(0, 12);
            send_message(len, $urandom_range(0, 1));
            n += len + 1;
        end
        // send one whole message, leave the next half done, then drop it with a mode write
        send_message(5, 0);
        send_beat(KIND_BYTE, 8'h11);
        set_mode(1'b0);
        send_beat(KIND_BYTE_END, 8'h22);
        idle_input();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        wait (digest_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && digest_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_dp.sv
src/sha256_224_stream_hasher_top.sv
test/sha256_224_stream_hasher_top_tb.sv
